[design/wlbs_pkg.sv]
// Package for the wall light band splitter.
// Holds the word layouts of the light, band and configuration channels and fixed widths.
// No dependencies.
`default_nettype none

package wlbs_pkg;

    localparam int HEIGHT_W = 32;
    localparam int INDEX_W  = 8;
    localparam int BANDS_W  = 8;

    typedef logic signed [HEIGHT_W-1:0] height_t;

    typedef struct packed {
        logic    no_lights;
        logic    is_last_light;
        height_t wall_top_left;
        height_t wall_top_right;
        height_t wall_bottom_left;
        height_t wall_bottom_right;
        height_t cut_left;
        height_t cut_right;
    } light_t;

    typedef struct packed {
        logic               band_valid;
        height_t            band_top_left;
        height_t            band_top_right;
        height_t            band_bottom_left;
        height_t            band_bottom_right;
        logic [INDEX_W-1:0] light_index;
        logic               keeps_own_light;
        logic               wall_done;
        logic               crosses_band;
    } band_t;

    typedef logic [BANDS_W-1:0] cfg_t;

    localparam cfg_t MAX_BANDS_RESET = cfg_t'(64);

endpackage

`default_nettype wire

[design/wlbs_chan.sv]
// Valid/ready channel interface used by every channel of the wall light band splitter.
// The payload type is a parameter; the package supplies the word layouts.
`default_nettype none

interface wlbs_chan #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/wall_light_band_split.sv]
// Top level of the wall light band splitter: configuration register, input register, core.
// Depends on wlbs_pkg, wlbs_chan, wlbs_in_reg and wlbs_split_core.
//
//   Channel   Dir  Word     Content
//   lights    in   light_t  one light of a wall with the wall bounds
//   bands     out  band_t   one result word for each light word
//   cfg       in   cfg_t    max_bands, bands emitted per wall at most
//
// One light word taken per cycle unless bands stalls; it passes input and result registers.
// The per-wall running state sits in a single register set updated once per word.
// A stalled result holds the core; the input register then fills and lights.ready drops.
// Reset clears all wall state and sets max_bands to 64; cfg.ready is always high.
`default_nettype none

module wall_light_band_split
    import wlbs_pkg::*;
#(
    parameter int MAX_LIGHTS = 256
)(
    input  wire logic clk,
    input  wire logic rst_n,
    wlbs_chan.sink    lights,
    wlbs_chan.source  bands,
    wlbs_chan.sink    cfg
);

    localparam int CNT_CAP = ((MAX_LIGHTS - 1) > 255) ? 255 : (MAX_LIGHTS - 1);

    cfg_t   max_bands_reg;
    logic   item_valid;
    light_t item;
    logic   advance;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bands_reg <= MAX_BANDS_RESET;
        end
        else if (cfg.valid)
        begin
            max_bands_reg <= cfg.data;
        end
    end

    wlbs_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .lights     (lights),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    wlbs_split_core #(
        .CNT_CAP (CNT_CAP)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .max_bands  (max_bands_reg),
        .advance    (advance),
        .bands      (bands)
    );

endmodule

`default_nettype wire

[design/wlbs_in_reg.sv]
// Input register of the wall light band splitter: holds one light word for the core.
// Depends on wlbs_pkg and the wlbs_chan interface.
`default_nettype none

module wlbs_in_reg
    import wlbs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    wlbs_chan.sink    lights,
    input  wire logic advance,
    output logic      item_valid,
    output light_t    item
);

    logic   valid_reg;
    logic   valid_next;
    light_t item_reg;
    logic   load;

    // The register frees up in the same cycle that the core consumes its word.
    assign lights.ready = !valid_reg || advance;
    assign load         = lights.valid && lights.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= lights.data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[design/wlbs_split_core.sv]
// Band decision logic, per-wall running state and result register of the splitter.
// Depends on wlbs_pkg and the wlbs_chan interface.
`default_nettype none

module wlbs_split_core
    import wlbs_pkg::*;
#(
    parameter int CNT_CAP = 255
)(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   item_valid,
    input  wire light_t item,
    input  wire cfg_t   max_bands,
    output logic        advance,
    wlbs_chan.source    bands
);

    localparam logic [INDEX_W-1:0] CAP = INDEX_W'(CNT_CAP);

    height_t             top_left_reg, top_right_reg;
    height_t             top_left_next, top_right_next;
    logic [INDEX_W-1:0]  count_reg, count_next;
    logic [BANDS_W-1:0]  emitted_reg, emitted_next;
    logic                finished_reg, finished_next;
    logic                decided_reg, decided_next;
    logic                cross_reg, cross_next;

    logic                res_valid_reg;
    band_t               res_reg, res_next;

    height_t             rt_left, rt_right;
    height_t             bot_left, bot_right, cut_l, cut_r;
    logic                room;
    logic                emit;
    height_t             e_top_l, e_top_r, e_bot_l, e_bot_r;
    logic                e_own;
    logic                cut_below_top;
    logic                cut_at_bottom;
    logic                cut_above_top;
    logic                cut_above_wall;

    assign advance = item_valid && (!res_valid_reg || bands.ready);

    always_comb
    begin
        bot_left  = item.wall_bottom_left;
        bot_right = item.wall_bottom_right;
        cut_l     = item.cut_left;
        cut_r     = item.cut_right;
        // The running top is taken from the wall top on a wall's first word.
        rt_left   = (count_reg == '0) ? item.wall_top_left  : top_left_reg;
        rt_right  = (count_reg == '0) ? item.wall_top_right : top_right_reg;

        cut_above_top  = (cut_l >= rt_left) && (cut_r >= rt_right);
        cut_at_bottom  = (cut_l <= bot_left) && (cut_r <= bot_right);
        cut_below_top  = (cut_l <= rt_left) && (cut_r <= rt_right)
                         && ((cut_l != rt_left) || (cut_r != rt_right));
        cut_above_wall = (cut_l >= item.wall_top_left) && (cut_r >= item.wall_top_right);

        top_left_next  = rt_left;
        top_right_next = rt_right;
        count_next     = count_reg;
        emitted_next   = emitted_reg;
        finished_next  = finished_reg;
        decided_next   = decided_reg;
        cross_next     = cross_reg;

        emit    = 1'b0;
        e_top_l = rt_left;
        e_top_r = rt_right;
        e_bot_l = bot_left;
        e_bot_r = bot_right;
        e_own   = 1'b0;

        res_next = '0;

        if (item.no_lights)
        begin
            // The word is the whole wall; any open wall is dropped.
            emit    = 1'b1;
            e_top_l = item.wall_top_left;
            e_top_r = item.wall_top_right;
            e_own   = 1'b1;
        end
        else if (!item.is_last_light)
        begin
            if (!decided_reg && !cut_above_wall)
            begin
                decided_next = 1'b1;
                cross_next   = !cut_at_bottom;
            end
            if (!finished_reg)
            begin
                if (cut_above_top)
                begin
                    emit = 1'b0;
                end
                else if (cut_at_bottom)
                begin
                    emit          = 1'b1;
                    e_own         = (count_reg == '0);
                    finished_next = 1'b1;
                end
                else
                begin
                    if (cut_below_top)
                    begin
                        emit           = 1'b1;
                        e_own          = (count_reg == '0);
                        e_bot_l        = cut_l;
                        e_bot_r        = cut_r;
                        top_left_next  = cut_l;
                        top_right_next = cut_r;
                    end
                    if ((top_left_next == bot_left) && (top_right_next == bot_right))
                    begin
                        finished_next = 1'b1;
                    end
                end
            end
            if (count_reg < CAP)
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            emit = !finished_reg;
        end

        // Without a light list the band count starts over from zero.
        room = item.no_lights ? (max_bands != '0) : (emitted_reg < max_bands);
        emit = emit && room && ((e_top_l > e_bot_l) || (e_top_r > e_bot_r));

        if (emit)
        begin
            res_next.band_valid        = 1'b1;
            res_next.band_top_left     = e_top_l;
            res_next.band_top_right    = e_top_r;
            res_next.band_bottom_left  = e_bot_l;
            res_next.band_bottom_right = e_bot_r;
            res_next.light_index       = item.no_lights ? '0 : count_reg;
            res_next.keeps_own_light   = e_own;
            emitted_next               = emitted_reg + 1'b1;
        end

        if (item.no_lights || item.is_last_light)
        begin
            res_next.wall_done    = 1'b1;
            res_next.crosses_band = !item.no_lights && decided_reg && cross_reg;
            top_left_next  = '0;
            top_right_next = '0;
            count_next     = '0;
            emitted_next   = '0;
            finished_next  = 1'b0;
            decided_next   = 1'b0;
            cross_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_left_reg  <= '0;
            top_right_reg <= '0;
            count_reg     <= '0;
            emitted_reg   <= '0;
            finished_reg  <= 1'b0;
            decided_reg   <= 1'b0;
            cross_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                top_left_reg  <= top_left_next;
                top_right_reg <= top_right_next;
                count_reg     <= count_next;
                emitted_reg   <= emitted_next;
                finished_reg  <= finished_next;
                decided_reg   <= decided_next;
                cross_reg     <= cross_next;
                res_valid_reg <= 1'b1;
            end
            else if (bands.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign bands.valid = res_valid_reg;
    assign bands.data  = res_reg;

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for wall_light_band_split: streams walls of light words and checks
// every band word against a behavioral predictor. Depends on wlbs_pkg, wlbs_chan and the RTL.

module testbench;
    import wlbs_pkg::*;

    localparam int     MAX_LIGHTS  = 256;
    localparam int     LIGHT_CAP   = (MAX_LIGHTS - 1 > 255) ? 255 : MAX_LIGHTS - 1;
    localparam int     CYCLE_LIMIT = 200000;
    localparam int     DRAIN_GAP   = 8;
    localparam int     PHASE_WORDS = 60;
    localparam longint H_MAX       = 64'sd2147483647;
    localparam longint H_MIN       = -64'sd2147483648;

    typedef enum int {CUT_STEP, CUT_SAME, CUT_ABOVE, CUT_AT_BOTTOM, CUT_BELOW, CUT_ANY} cut_kind_e;

    bit clk = 1'b0;
    bit rst_n = 1'b0;

    wlbs_chan #(.payload_t(light_t)) light_ch ();
    wlbs_chan #(.payload_t(band_t))  band_ch ();
    wlbs_chan #(.payload_t(cfg_t))   cfg_ch ();

    wall_light_band_split #(
        .MAX_LIGHTS(MAX_LIGHTS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .lights (light_ch),
        .bands  (band_ch),
        .cfg    (cfg_ch)
    );

    always #4 clk = ~clk;

    light_t lights_todo[$];
    band_t  bands_due[$];
    int     pushed_count = 0;
    int     errors = 0;
    int     cycles = 0;
    bit     idling = 1'b1;
    bit     lights_went = 1'b0;
    bit     cfg_went = 1'b0;

    // Predictor state for the wall in progress.
    cfg_t    band_cap = MAX_BANDS_RESET;
    height_t top_left_now = '0;
    height_t top_right_now = '0;
    int      light_count = 0;
    int      bands_out = 0;
    bit      wall_closed = 1'b0;
    bit      cross_known = 1'b0;
    bit      cross_bit = 1'b0;

    function automatic void clear_wall();
        top_left_now  = '0;
        top_right_now = '0;
        light_count   = 0;
        bands_out     = 0;
        wall_closed   = 1'b0;
        cross_known   = 1'b0;
        cross_bit     = 1'b0;
    endfunction

    function automatic void offer_band(inout band_t r, input height_t tl, tr, bl, br,
                                       input int idx, input bit own);
        if (bands_out >= int'(band_cap))
            return;
        if (!(tl > bl || tr > br))
            return;
        bands_out++;
        r.band_valid        = 1'b1;
        r.band_top_left     = tl;
        r.band_top_right    = tr;
        r.band_bottom_left  = bl;
        r.band_bottom_right = br;
        r.light_index       = idx[INDEX_W-1:0];
        r.keeps_own_light   = own;
    endfunction

    function automatic band_t predict_band(light_t w);
        band_t   r;
        height_t cl, cr, wbl, wbr;
        int      idx;
        r   = '0;
        cl  = w.cut_left;
        cr  = w.cut_right;
        wbl = w.wall_bottom_left;
        wbr = w.wall_bottom_right;
        if (w.no_lights) begin
            clear_wall();
            offer_band(r, w.wall_top_left, w.wall_top_right, wbl, wbr, 0, 1'b1);
            r.wall_done = 1'b1;
            clear_wall();
            return r;
        end
        if (light_count == 0) begin
            top_left_now  = w.wall_top_left;
            top_right_now = w.wall_top_right;
        end
        idx = light_count;
        if (w.is_last_light) begin
            if (!wall_closed)
                offer_band(r, top_left_now, top_right_now, wbl, wbr, idx, 1'b0);
            r.wall_done    = 1'b1;
            r.crosses_band = cross_known && cross_bit;
            clear_wall();
            return r;
        end
        // The crossing test looks at this word's wall top, not the running top.
        if (!cross_known && !(cl >= height_t'(w.wall_top_left)
                              && cr >= height_t'(w.wall_top_right))) begin
            cross_known = 1'b1;
            cross_bit   = !(cl <= wbl && cr <= wbr);
        end
        if (!wall_closed) begin
            if (cl >= top_left_now && cr >= top_right_now) begin
                // Light lies above what is left of the wall.
            end
            else if (cl <= wbl && cr <= wbr) begin
                offer_band(r, top_left_now, top_right_now, wbl, wbr, idx, idx == 0);
                wall_closed = 1'b1;
            end
            else begin
                if (cl <= top_left_now && cr <= top_right_now
                    && (cl != top_left_now || cr != top_right_now)) begin
                    offer_band(r, top_left_now, top_right_now, cl, cr, idx, idx == 0);
                    top_left_now  = cl;
                    top_right_now = cr;
                end
                if (top_left_now == wbl && top_right_now == wbr)
                    wall_closed = 1'b1;
            end
        end
        if (light_count < LIGHT_CAP)
            light_count++;
        return r;
    endfunction

    function automatic bit take_a_break();
        return idling && ($urandom_range(99) < 13);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // Stimulus helpers.
    function automatic height_t clamp_h(longint v);
        if (v > H_MAX)
            return height_t'(H_MAX);
        if (v < H_MIN)
            return height_t'(H_MIN);
        return height_t'(v);
    endfunction

    function automatic height_t fx(int units);
        return height_t'(units <<< 16);
    endfunction

    function automatic height_t any_height();
        int pick;
        pick = $urandom_range(15);
        case (pick)
            0:       return height_t'(H_MAX);
            1:       return height_t'(H_MIN);
            2:       return '0;
            3:       return '1;
            4, 5, 6, 7, 8:
                     return height_t'($urandom);
            default: return clamp_h((longint'($urandom_range(0, 2000)) - 1000) * 65536
                                    + longint'($urandom_range(0, 65535)));
        endcase
    endfunction

    function automatic height_t wall_height();
        if ($urandom_range(4) == 0)
            return any_height();
        return clamp_h((longint'($urandom_range(0, 400)) - 200) * 65536
                       + longint'($urandom_range(0, 65535)));
    endfunction

    function automatic cut_kind_e pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 55) return CUT_STEP;
        if (r < 63) return CUT_SAME;
        if (r < 72) return CUT_ABOVE;
        if (r < 80) return CUT_AT_BOTTOM;
        if (r < 88) return CUT_BELOW;
        return CUT_ANY;
    endfunction

    function automatic height_t next_cut(cut_kind_e k, height_t cur, height_t bot,
                                         height_t top, bit fine);
        longint span;
        span = longint'(cur) - longint'(bot);
        case (k)
            CUT_STEP: begin
                if (span <= 0)
                    return clamp_h(longint'(cur) - longint'($urandom_range(0, 3)));
                if (fine)
                    return clamp_h(longint'(cur) - longint'($urandom_range(1, 5000)));
                return clamp_h(longint'(cur) - span * longint'($urandom_range(1, 99)) / 100);
            end
            CUT_SAME:      return cur;
            CUT_ABOVE:     return clamp_h(longint'(top) + longint'($urandom_range(0, 1000)));
            CUT_AT_BOTTOM: return bot;
            CUT_BELOW:     return clamp_h(longint'(bot) - longint'($urandom_range(0, 1000)));
            default:       return any_height();
        endcase
    endfunction

    function automatic void add_light(light_t w);
        lights_todo.push_back(w);
        pushed_count++;
    endfunction

    function automatic void put(bit nol, bit last, height_t tl, tr, bl, br, cl, cr);
        light_t w;
        w.no_lights         = nol;
        w.is_last_light     = last;
        w.wall_top_left     = tl;
        w.wall_top_right    = tr;
        w.wall_bottom_left  = bl;
        w.wall_bottom_right = br;
        w.cut_left          = cl;
        w.cut_right         = cr;
        add_light(w);
    endfunction

    // A wall of n light words with descending cuts and some disorder. Without ends_wall the
    // last word is not marked, which leaves the wall open.
    function automatic void push_wall(int n, bit fine, bit ends_wall);
        light_t    w, item;
        height_t   a, b, cur_l, cur_r;
        cut_kind_e kl, kr;
        w = '0;
        a = wall_height();
        b = wall_height();
        w.wall_top_left    = (a > b) ? a : b;
        w.wall_bottom_left = (a > b) ? b : a;
        a = wall_height();
        b = wall_height();
        w.wall_top_right    = (a > b) ? a : b;
        w.wall_bottom_right = (a > b) ? b : a;
        if (!fine && $urandom_range(9) == 0) begin
            w.wall_bottom_left  = w.wall_top_left;
            w.wall_bottom_right = w.wall_top_right;
        end
        cur_l = w.wall_top_left;
        cur_r = w.wall_top_right;
        for (int k = 0; k < n; k++) begin
            item = w;
            item.is_last_light = ends_wall && (k == n - 1);
            if (fine) begin
                kl = ($urandom_range(19) == 0) ? CUT_SAME : CUT_STEP;
                kr = kl;
            end
            else begin
                if ($urandom_range(11) == 0)
                    item.wall_bottom_left = wall_height();
                if ($urandom_range(11) == 0)
                    item.wall_bottom_right = wall_height();
                if ($urandom_range(11) == 0)
                    item.wall_top_right = wall_height();
                kl = pick_kind();
                kr = ($urandom_range(4) == 0) ? pick_kind() : kl;
            end
            item.cut_left  = next_cut(kl, cur_l, item.wall_bottom_left, w.wall_top_left, fine);
            item.cut_right = next_cut(kr, cur_r, item.wall_bottom_right, w.wall_top_right, fine);
            if (item.cut_left <= cur_l && item.cut_right <= cur_r) begin
                cur_l = item.cut_left;
                cur_r = item.cut_right;
            end
            add_light(item);
        end
    endfunction

    function automatic void push_lone_wall(bit noisy);
        height_t a, b;
        a = noisy ? any_height() : wall_height();
        b = noisy ? any_height() : wall_height();
        put(1'b1, $urandom_range(1), (a > b) ? a : b, any_height(), (a > b) ? b : a,
            any_height(), any_height(), any_height());
    endfunction

    function automatic void push_noise();
        put($urandom_range(7) == 0, $urandom_range(2) == 0, any_height(), any_height(),
            any_height(), any_height(), any_height(), any_height());
    endfunction

    function automatic void push_random_words(int target);
        int start, r;
        start = pushed_count;
        while (pushed_count - start < target) begin
            r = $urandom_range(99);
            if (r < 58)
                push_wall($urandom_range(2, 8), $urandom_range(3) == 0, 1'b1);
            else if (r < 66)
                push_wall(1, 1'b0, 1'b1);
            else if (r < 76)
                push_lone_wall($urandom_range(1));
            else if (r < 86) begin
                // An open wall cut short by a word with no light list.
                push_wall($urandom_range(1, 4), 1'b0, 1'b0);
                push_lone_wall(1'b0);
            end
            else
                push_noise();
        end
    endfunction

    function automatic void push_directed();
        put(1'b1, 1'b0, height_t'(H_MAX), height_t'(H_MAX), height_t'(H_MIN), height_t'(H_MIN),
            '0, '0);
        put(1'b1, 1'b1, fx(5), fx(5), fx(5), fx(5), '1, '1);
        put(1'b0, 1'b1, fx(10), fx(12), fx(0), fx(-3), height_t'(H_MAX), height_t'(H_MIN));
        // Skip, cut, repeat, crossing cut, close, then words after closing.
        put(1'b0, 1'b0, fx(100), fx(100), fx(0), fx(0), fx(150), fx(150));
        put(1'b0, 1'b0, fx(100), fx(100), fx(0), fx(0), fx(60), fx(60));
        put(1'b0, 1'b0, fx(100), fx(100), fx(0), fx(0), fx(60), fx(60));
        put(1'b0, 1'b0, fx(100), fx(100), fx(0), fx(0), fx(70), fx(50));
        put(1'b0, 1'b0, fx(100), fx(100), fx(0), fx(0), fx(-10), fx(-10));
        put(1'b0, 1'b0, fx(100), fx(100), fx(0), fx(0), fx(30), fx(30));
        put(1'b0, 1'b1, fx(100), fx(100), fx(0), fx(0), fx(20), fx(20));
        // Own-light band, then a cut exactly at the wall bottom.
        put(1'b0, 1'b0, fx(40), fx(80), fx(-20), fx(-20), fx(10), fx(30));
        put(1'b0, 1'b0, fx(40), fx(80), fx(-20), fx(-20), fx(-20), fx(-20));
        put(1'b0, 1'b1, fx(40), fx(80), fx(-20), fx(-20), '0, '0);
        // First light below the bottom takes the whole wall.
        put(1'b0, 1'b0, fx(50), fx(50), fx(0), fx(0), fx(-5), fx(-1));
        put(1'b0, 1'b1, fx(50), fx(50), fx(0), fx(0), '0, '0);
        // A raised bottom meets the running top and closes the wall.
        put(1'b0, 1'b0, fx(60), fx(60), fx(0), fx(0), fx(20), fx(20));
        put(1'b0, 1'b0, fx(60), fx(60), fx(20), fx(20), fx(25), fx(10));
        put(1'b0, 1'b0, fx(60), fx(60), fx(0), fx(0), fx(5), fx(5));
        put(1'b0, 1'b1, fx(60), fx(60), fx(0), fx(0), '0, '0);
        // Open wall abandoned by a word with no light list.
        put(1'b0, 1'b0, fx(30), fx(30), fx(0), fx(0), fx(15), fx(15));
        put(1'b1, 1'b0, fx(7), fx(9), fx(-1), fx(2), '0, '0);
        // Wall of zero height: nothing is emitted.
        put(1'b0, 1'b0, '0, '0, '0, '0, '1, '1);
        put(1'b0, 1'b1, '0, '0, '0, '0, '0, '0);
        // Extreme cuts across the wall; the last word has an inverted left end.
        put(1'b0, 1'b0, fx(10), fx(10), fx(0), fx(0), height_t'(H_MAX), height_t'(H_MIN));
        put(1'b0, 1'b1, fx(10), fx(10), fx(20), fx(0), '0, '0);
    endfunction

    // Light word driver.
    always @(negedge clk) begin
        if (!light_ch.valid || lights_went) begin
            if (lights_todo.size() != 0 && !take_a_break()) begin
                light_ch.data  <= lights_todo.pop_front();
                light_ch.valid <= 1'b1;
            end
            else
                light_ch.valid <= 1'b0;
        end
    end

    // Band word receiver.
    always @(negedge clk)
        band_ch.ready <= !take_a_break();

    always @(posedge clk) begin : monitor
        band_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
        else begin
            lights_went <= light_ch.valid && light_ch.ready;
            cfg_went    <= cfg_ch.valid && cfg_ch.ready;
            if (rst_n) begin
                if (band_ch.valid && band_ch.ready) begin
                    if (bands_due.size() == 0) begin
                        errors++;
                        $display("%0t: band word with none expected: expected nothing, actual %p",
                                 $time, band_ch.data);
                    end
                    else begin
                        want = bands_due.pop_front();
                        check_field("band_valid", want.band_valid, band_ch.data.band_valid);
                        check_field("band_top_left", want.band_top_left,
                                    band_ch.data.band_top_left);
                        check_field("band_top_right", want.band_top_right,
                                    band_ch.data.band_top_right);
                        check_field("band_bottom_left", want.band_bottom_left,
                                    band_ch.data.band_bottom_left);
                        check_field("band_bottom_right", want.band_bottom_right,
                                    band_ch.data.band_bottom_right);
                        check_field("light_index", want.light_index, band_ch.data.light_index);
                        check_field("keeps_own_light", want.keeps_own_light,
                                    band_ch.data.keeps_own_light);
                        check_field("wall_done", want.wall_done, band_ch.data.wall_done);
                        check_field("crosses_band", want.crosses_band,
                                    band_ch.data.crosses_band);
                    end
                end
                if (cfg_ch.valid && cfg_ch.ready)
                    band_cap = cfg_ch.data;
                if (light_ch.valid && light_ch.ready)
                    bands_due.push_back(predict_band(light_ch.data));
            end
        end
    end

    task automatic write_cap(cfg_t value);
        @(negedge clk);
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_went);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (lights_todo.size() != 0 || light_ch.valid || bands_due.size() != 0);
        repeat (DRAIN_GAP) @(negedge clk);
    endtask

    initial begin
        cfg_t caps[7];
        light_ch.valid = 1'b0;
        light_ch.data  = '0;
        band_ch.ready  = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        caps = '{MAX_BANDS_RESET, cfg_t'(0), cfg_t'(255), cfg_t'(1), cfg_t'(2),
                 cfg_t'($urandom_range(3, 254)), cfg_t'(64)};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < 7; p++) begin
            // One phase runs with no idling on either side.
            idling = (p != 3);
            if (p > 0)
                write_cap(caps[p]);
            if (p == 0)
                push_directed();
            if (p == 2)
                push_wall(300, 1'b1, 1'b1);
            push_random_words(PHASE_WORDS);
            drain();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[wall_light_band_split.f]
design/wlbs_pkg.sv
design/wlbs_chan.sv
design/wlbs_in_reg.sv
design/wlbs_split_core.sv
design/wall_light_band_split.sv
bench/testbench.sv
